>>> rtl/gem_pkg.sv
// shared constants and types for the gradient edge mask unit
`default_nettype none

package gem_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int WIDTH_REG_W = 12;
  localparam int THRESH_W    = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;
  localparam int CHAN_W      = 8;
  localparam int NUM_CHAN    = 3;
  localparam int PIX_W       = NUM_CHAN * CHAN_W;
  localparam int HALF_W      = CHAN_W - 1;
  localparam int SQ_W        = 2 * HALF_W;
  localparam int SUM_W       = 16;
  localparam int CNT_W       = (COL_W + 1 > WIDTH_REG_W) ? COL_W + 1 : WIDTH_REG_W;

  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET = WIDTH_REG_W'(640);

  localparam logic [CFG_INDEX_W-1:0] REG_EDGE_THRESHOLD = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH    = CFG_INDEX_W'(1);

  typedef logic [PIX_W-1:0] pixel_t;

endpackage

`default_nettype wire

>>> rtl/gem_row_ram.sv
// single port row memory, read-first, registered read data
`default_nettype none

module gem_row_ram #(
  parameter int DEPTH  = 2048,
  parameter int DATA_W = 24
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [DATA_W-1:0]        wdata,
  output logic      [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      rdata     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

endmodule

`default_nettype wire

>>> rtl/gem_grad_sum.sv
// sum over the channels of squared halved differences between two pixels
`default_nettype none

module gem_grad_sum (
  input  wire gem_pkg::pixel_t          pix_a,
  input  wire gem_pkg::pixel_t          pix_b,
  output logic [gem_pkg::SUM_W-1:0]     sum
);

  logic [gem_pkg::CHAN_W-1:0] abs_diff [gem_pkg::NUM_CHAN];
  logic [gem_pkg::HALF_W-1:0] half     [gem_pkg::NUM_CHAN];
  logic [gem_pkg::SQ_W-1:0]   sq       [gem_pkg::NUM_CHAN];

  always_comb begin
    for (int i = 0; i < gem_pkg::NUM_CHAN; i++) begin
      if (pix_a[i*gem_pkg::CHAN_W +: gem_pkg::CHAN_W] >=
          pix_b[i*gem_pkg::CHAN_W +: gem_pkg::CHAN_W]) begin
        abs_diff[i] = pix_a[i*gem_pkg::CHAN_W +: gem_pkg::CHAN_W] -
                      pix_b[i*gem_pkg::CHAN_W +: gem_pkg::CHAN_W];
      end else begin
        abs_diff[i] = pix_b[i*gem_pkg::CHAN_W +: gem_pkg::CHAN_W] -
                      pix_a[i*gem_pkg::CHAN_W +: gem_pkg::CHAN_W];
      end
      // halving the magnitude truncates toward zero
      half[i] = abs_diff[i][gem_pkg::CHAN_W-1:1];
      sq[i]   = gem_pkg::SQ_W'(half[i]) * gem_pkg::SQ_W'(half[i]);
    end
  end

  assign sum = gem_pkg::SUM_W'(sq[0]) + gem_pkg::SUM_W'(sq[1]) + gem_pkg::SUM_W'(sq[2]);

endmodule

`default_nettype wire

>>> rtl/gradient_edge_mask_unit.sv
// top level of the gradient edge mask unit
// a pixel is registered in stage one, then in the result register, at one pixel per cycle
// unless out_ready stalls, set by the single port row memory (one read and write per pixel)
// rst clears config to threshold 0 and width 640, column to 0, first row flag to 1
// row memory contents are not cleared by reset and need no clearing pass
`default_nettype none

module gradient_edge_mask_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               start_of_frame,
  input  wire logic [7:0]                         red,
  input  wire logic [7:0]                         green,
  input  wire logic [7:0]                         blue,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    edge_res,
  output logic                                    horizontal_hit,
  output logic                                    vertical_hit,
  input  wire logic                               cfg_we,
  input  wire logic [gem_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [gem_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [gem_pkg::THRESH_W-1:0]    edge_threshold;
  logic [gem_pkg::WIDTH_REG_W-1:0] image_width;

  gem_pkg::pixel_t              previous_pixel;
  logic [gem_pkg::COL_W-1:0]    column_count;
  logic                         in_first_row;
  logic [gem_pkg::COL_W-1:0]    column_count_next;
  logic                         in_first_row_next;

  logic                         s1_valid;
  gem_pkg::pixel_t              s1_pix;
  gem_pkg::pixel_t              s1_prev;
  logic                         s1_h_en;
  logic                         s1_v_en;

  gem_pkg::pixel_t              in_pix;
  gem_pkg::pixel_t              row_above;
  logic                         in_accept;
  logic                         out_free;
  logic [gem_pkg::COL_W-1:0]    col_cur;
  logic                         first_cur;
  logic [gem_pkg::CNT_W-1:0]    width_eff;
  logic [gem_pkg::CNT_W-1:0]    col_plus;
  logic [gem_pkg::SUM_W-1:0]    hsum;
  logic [gem_pkg::SUM_W-1:0]    vsum;
  logic                         hhit;
  logic                         vhit;

  assign in_pix    = {blue, green, red};
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = !s1_valid || out_free;
  assign in_accept = in_valid && in_ready;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_threshold <= '0;
      image_width    <= gem_pkg::WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gem_pkg::REG_EDGE_THRESHOLD: edge_threshold <= gem_pkg::THRESH_W'(cfg_data);
        gem_pkg::REG_IMAGE_WIDTH:    image_width    <= gem_pkg::WIDTH_REG_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // column tracking
  always_comb begin
    width_eff = gem_pkg::CNT_W'(image_width);
    if (width_eff == '0) begin
      width_eff = gem_pkg::CNT_W'(1);
    end else if (width_eff > gem_pkg::CNT_W'(gem_pkg::MAX_WIDTH)) begin
      width_eff = gem_pkg::CNT_W'(gem_pkg::MAX_WIDTH);
    end
    col_cur   = start_of_frame ? '0 : column_count;
    first_cur = start_of_frame ? 1'b1 : in_first_row;
    if (gem_pkg::CNT_W'(col_cur) >= gem_pkg::CNT_W'(gem_pkg::MAX_WIDTH)) begin
      col_cur = '0;
    end
    col_plus = gem_pkg::CNT_W'(col_cur) + gem_pkg::CNT_W'(1);
    if (col_plus >= width_eff) begin
      column_count_next = '0;
      in_first_row_next = 1'b0;
    end else begin
      column_count_next = col_plus[gem_pkg::COL_W-1:0];
      in_first_row_next = first_cur;
    end
  end

  gem_row_ram #(
    .DEPTH  (gem_pkg::MAX_WIDTH),
    .DATA_W (gem_pkg::PIX_W)
  ) u_row_ram (
    .clk   (clk),
    .en    (in_accept),
    .addr  (col_cur),
    .wdata (in_pix),
    .rdata (row_above)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_pixel <= '0;
      column_count   <= '0;
      in_first_row   <= 1'b1;
      s1_valid       <= 1'b0;
    end else begin
      if (in_accept) begin
        previous_pixel <= in_pix;
        column_count   <= column_count_next;
        in_first_row   <= in_first_row_next;
        s1_valid       <= 1'b1;
      end else if (out_free) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix  <= in_pix;
      s1_prev <= previous_pixel;
      s1_h_en <= !start_of_frame;
      s1_v_en <= !first_cur;
    end
  end

  gem_grad_sum u_hgrad (
    .pix_a (s1_pix),
    .pix_b (s1_prev),
    .sum   (hsum)
  );

  gem_grad_sum u_vgrad (
    .pix_a (s1_pix),
    .pix_b (row_above),
    .sum   (vsum)
  );

  assign hhit = s1_h_en && (gem_pkg::THRESH_W'(hsum) > edge_threshold);
  assign vhit = s1_v_en && (gem_pkg::THRESH_W'(vsum) > edge_threshold);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      edge_res       <= hhit || vhit;
      horizontal_hit <= hhit;
      vertical_hit   <= vhit;
    end
  end

endmodule

`default_nettype wire

>>> rtl/gem_checker.sv
// port level checker for the gradient edge mask unit, with its bind
`default_nettype none

module gem_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic edge_res,
  input wire logic horizontal_hit,
  input wire logic vertical_hit
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_edge_is_or: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (edge_res == (horizontal_hit || vertical_hit)))
    else $error("edge result differs from the hit flags");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(edge_res) && $stable(horizontal_hit) && $stable(vertical_hit)))
    else $error("stalled result transaction changed");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input not ready while the result register is empty");

endmodule

bind gradient_edge_mask_unit gem_checker u_gem_checker (.*);

`default_nettype wire

>>> verif/tb_top.sv
// self-checking testbench for the gradient edge mask unit with pixel stream driver and mask monitor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gem_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int          RANDOM_ITEMS = 950;

  typedef struct packed {
    logic             sof;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_txn_t;

  typedef struct packed {
    logic edge_res;
    logic h_hit;
    logic v_hit;
  } mask_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   start_of_frame = 1'b0;
  logic [CHAN_W-1:0]      red = '0;
  logic [CHAN_W-1:0]      green = '0;
  logic [CHAN_W-1:0]      blue = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   edge_res;
  logic                   horizontal_hit;
  logic                   vertical_hit;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  gradient_edge_mask_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .start_of_frame (start_of_frame),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .edge_res       (edge_res),
    .horizontal_hit (horizontal_hit),
    .vertical_hit   (vertical_hit),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  pixel_txn_t   pixel_backlog[$];
  mask_result_t mask_expected[$];

  int unsigned tx_max_gap = 0;
  int unsigned rx_max_stall = 0;
  bit          long_hold_req = 1'b0;
  int unsigned mismatch_count = 0;

  // predictor state
  logic [THRESH_W-1:0]    thr_reg = '0;
  logic [WIDTH_REG_W-1:0] width_reg = WIDTH_RESET;
  pixel_t                 prev_pix = '0;
  pixel_t                 row_mem [MAX_WIDTH];
  int unsigned            col_pos = 0;
  bit                     first_row = 1'b1;
  int unsigned            span_written = 0;

  function automatic int unsigned grad_energy(input pixel_t a, input pixel_t b);
    int          d;
    int unsigned total;
    total = 0;
    for (int k = 0; k < NUM_CHAN; k++) begin
      d = (int'(a[k*CHAN_W +: CHAN_W]) - int'(b[k*CHAN_W +: CHAN_W])) / 2;
      total += d * d;
    end
    return total;
  endfunction

  function automatic void predict_mask(input pixel_txn_t px);
    pixel_t       pix;
    int unsigned  w_eff;
    int unsigned  hsum;
    int unsigned  vsum;
    mask_result_t res;
    pix = {px.blue, px.green, px.red};
    w_eff = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    hsum = 0;
    vsum = 0;
    if (px.sof) begin
      col_pos = 0;
      first_row = 1'b1;
    end else begin
      hsum = grad_energy(pix, prev_pix);
    end
    if (col_pos >= MAX_WIDTH) col_pos = 0;
    if (!first_row) vsum = grad_energy(pix, row_mem[col_pos]);
    res.h_hit = hsum > thr_reg;
    res.v_hit = vsum > thr_reg;
    res.edge_res = res.h_hit | res.v_hit;
    row_mem[col_pos] = pix;
    if (col_pos + 1 > span_written) span_written = col_pos + 1;
    prev_pix = pix;
    if (col_pos + 1 >= w_eff) begin
      col_pos = 0;
      first_row = 1'b0;
    end else begin
      col_pos++;
    end
    mask_expected.push_back(res);
  endfunction

  // driver
  pixel_txn_t next_px;
  int unsigned tx_wait;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait <= 0;
    end else if (in_valid && !in_ready) begin
      // hold the offered transaction
    end else if (tx_wait != 0) begin
      in_valid <= 1'b0;
      tx_wait <= tx_wait - 1;
    end else if (pixel_backlog.size() != 0) begin
      next_px = pixel_backlog.pop_front();
      start_of_frame <= next_px.sof;
      red <= next_px.red;
      green <= next_px.green;
      blue <= next_px.blue;
      in_valid <= 1'b1;
      tx_wait <= $urandom_range(0, tx_max_gap);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver
  int unsigned rx_wait;
  int unsigned rx_draw;
  int unsigned hold_left;
  bit          hold_taken;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait <= 0;
      hold_left <= 0;
      hold_taken <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold_req && !hold_taken) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_taken <= 1'b1;
    end else if (out_valid && out_ready) begin
      rx_draw = $urandom_range(0, rx_max_stall);
      out_ready <= (rx_draw == 0);
      rx_wait <= rx_draw;
    end else if (rx_wait != 0) begin
      out_ready <= 1'b0;
      rx_wait <= rx_wait - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor
  mask_result_t want;
  mask_result_t seen;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) predict_mask({start_of_frame, red, green, blue});
      if (out_valid && out_ready) begin
        seen = {edge_res, horizontal_hit, vertical_hit};
        if (mask_expected.size() == 0) begin
          if (mismatch_count < MAX_REPORTS)
            $display("unexpected result transaction: edge=%0b h=%0b v=%0b",
                     seen.edge_res, seen.h_hit, seen.v_hit);
          mismatch_count++;
        end else begin
          want = mask_expected.pop_front();
          if (want != seen) begin
            if (mismatch_count < MAX_REPORTS)
              $display("mask mismatch: expected edge=%0b h=%0b v=%0b, got edge=%0b h=%0b v=%0b",
                       want.edge_res, want.h_hit, want.v_hit,
                       seen.edge_res, seen.h_hit, seen.v_hit);
            mismatch_count++;
          end
        end
      end
    end
  end

  // watchdog
  int unsigned cycle_count = 0;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_pixel(input bit sof, input int r, input int g, input int b);
    pixel_txn_t px;
    px.sof = sof;
    px.red = r[CHAN_W-1:0];
    px.green = g[CHAN_W-1:0];
    px.blue = b[CHAN_W-1:0];
    pixel_backlog.push_back(px);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_backlog.size() != 0 || in_valid || mask_expected.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_EDGE_THRESHOLD) thr_reg = val[THRESH_W-1:0];
    else width_reg = val[WIDTH_REG_W-1:0];
  endtask

  task automatic configure(input int thr, input int wreg, input int gap, input int stall);
    wait_drained();
    write_reg(REG_EDGE_THRESHOLD, thr[CFG_DATA_W-1:0]);
    write_reg(REG_IMAGE_WIDTH, {4'($urandom), wreg[WIDTH_REG_W-1:0]});
    @(negedge clk);
    tx_max_gap = gap;
    rx_max_stall = stall;
  endtask

  function automatic int unsigned pick_gap();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 2;
      default: return 18;
    endcase
  endfunction

  function automatic int next_chan(input int prev, input int mode);
    int v;
    case (mode)
      0, 1, 2, 3, 4: begin
        v = prev + int'($urandom_range(0, 16)) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v;
      end
      5: return $urandom_range(0, 1) ? 255 : 0;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  int last_r = 0;
  int last_g = 0;
  int last_b = 0;

  task automatic random_phase(input int n_req, input bit with_hold, output int n_done);
    int  thr;
    int  wreg;
    int  w_eff;
    int  n_items;
    bit  lead_sof;
    bit  sof;
    int  col;
    int  row;
    int  frame_rows;
    int  mode;
    n_items = n_req;
    case ($urandom_range(0, 9))
      0: thr = 0;
      1: thr = 65535;
      2: thr = 48386;
      3: thr = 48387;
      4: thr = $urandom_range(0, 64);
      5, 6: thr = $urandom_range(0, 600);
      default: thr = $urandom_range(0, 8000);
    endcase
    case ($urandom_range(0, 19))
      0: wreg = 0;
      1: wreg = 4095;
      2: wreg = MAX_WIDTH;
      3: wreg = MAX_WIDTH + 1;
      4: wreg = $urandom_range(17, 64);
      default: wreg = $urandom_range(1, 12);
    endcase
    w_eff = (wreg == 0) ? 1 : ((wreg > MAX_WIDTH) ? MAX_WIDTH : wreg);
    if (w_eff > 64) n_items = $urandom_range(8, 24);
    configure(thr, wreg, pick_gap(), pick_gap());
    // a row store column never written must not be read, so a wider row restarts the frame
    lead_sof = ($urandom_range(0, 9) < 7) || (w_eff > span_written);
    if (with_hold) begin
      tx_max_gap = 0;
      long_hold_req = 1'b1;
    end
    col = lead_sof ? 0 : col_pos;
    row = 0;
    frame_rows = $urandom_range(2, 6);
    for (int k = 0; k < n_items; k++) begin
      sof = (k == 0 && lead_sof) || (col == 0 && row >= frame_rows) ||
            ($urandom_range(0, 39) == 0);
      if (sof) begin
        col = 0;
        row = 0;
        frame_rows = $urandom_range(2, 6);
      end
      mode = $urandom_range(0, 9);
      last_r = next_chan(last_r, mode);
      last_g = next_chan(last_g, mode);
      last_b = next_chan(last_b, mode);
      queue_pixel(sof, last_r, last_g, last_b);
      col++;
      if (col >= w_eff) begin
        col = 0;
        row++;
      end
    end
    n_done = n_items;
  endtask

  int generated;
  int added;
  int phase_no;

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // stream begun without a frame start, registers at reset values
    @(negedge clk);
    tx_max_gap = 18;
    rx_max_stall = 18;
    queue_pixel(0, 255, 255, 255);
    queue_pixel(0, 254, 254, 254);
    queue_pixel(0, 252, 255, 253);
    queue_pixel(0, 0, 0, 0);

    // odd differences truncate toward zero, rows of three, frame restart mid-row
    configure(0, 3, 0, 0);
    queue_pixel(1, 10, 20, 30);
    queue_pixel(0, 11, 21, 31);
    queue_pixel(0, 13, 20, 30);
    queue_pixel(0, 0, 0, 0);
    queue_pixel(0, 11, 21, 31);
    queue_pixel(0, 255, 0, 128);
    queue_pixel(0, 0, 255, 0);
    queue_pixel(1, 9, 9, 9);

    // full-scale swings against a threshold one below the largest sum, zero width
    configure(48386, 0, 2, 18);
    queue_pixel(1, 0, 0, 0);
    queue_pixel(0, 255, 255, 255);
    queue_pixel(0, 0, 0, 0);
    queue_pixel(0, 0, 255, 255);

    // threshold equal to the largest sum never fires
    configure(48387, 1, 18, 2);
    queue_pixel(0, 255, 255, 255);
    queue_pixel(0, 0, 0, 0);

    // top threshold and a width beyond the row store
    configure(65535, 4095, 2, 2);
    queue_pixel(1, 255, 0, 255);
    queue_pixel(0, 0, 255, 0);
    queue_pixel(0, 255, 255, 255);

    generated = 0;
    phase_no = 0;
    while (generated < RANDOM_ITEMS) begin
      random_phase($urandom_range(40, 120), phase_no == 2, added);
      generated += added;
      phase_no++;
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
